>>> design/asbc_pkg.sv
// shared types and constants for the arp spoof binding checker
// used by asbc_ctrl, asbc_dp and arp_spoof_binding_checker
`default_nettype none

package asbc_pkg;

    // default number of bindings in the table
    localparam int TABLE_DEPTH_DEF = 64;

    localparam int OPCODE_W = 16;
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int VERDICT_W = 3;
    localparam int COUNT_W  = 7;

    localparam logic [OPCODE_W-1:0] OP_REQUEST = 16'd1;
    localparam logic [OPCODE_W-1:0] OP_REPLY   = 16'd2;

    typedef enum logic [VERDICT_W-1:0] {
        V_LEARNED = 3'd0,
        V_MATCH   = 3'd1,
        V_SPOOF   = 3'd2,
        V_UNKNOWN = 3'd3,
        V_FULL    = 3'd4,
        V_HALTED  = 3'd5
    } t_verdict;

    // controller to datapath
    typedef struct packed {
        logic     load;        // capture the input word
        logic     scan_start;  // begin table search at entry zero
        logic     insert;      // write binding at fill position, bump count
        logic     emit;        // register a result this cycle
        t_verdict verdict;     // verdict of that result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic halted;
        logic op_ok;
        logic empty;
        logic full;
        logic hit;     // registered read entry matches the ip
        logic miss;    // last entry read, no match
        logic mac_eq;  // registered read entry mac equals the packet mac
    } t_status;

endpackage

`default_nettype wire

>>> design/asbc_ctrl.sv
// control state machine of the arp spoof binding checker
// depends on asbc_pkg
`default_nettype none

module asbc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire asbc_pkg::t_status i_status,
    output asbc_pkg::t_cmd         o_cmd,
    output logic                   busy
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_SCAN  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state           = r_state;
        o_cmd.load        = 1'b0;
        o_cmd.scan_start  = 1'b0;
        o_cmd.insert      = 1'b0;
        o_cmd.emit        = 1'b0;
        o_cmd.verdict     = asbc_pkg::V_LEARNED;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.halted) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.verdict = asbc_pkg::V_HALTED;
                    n_state       = S_IDLE;
                end else if (!i_status.op_ok) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.verdict = asbc_pkg::V_UNKNOWN;
                    n_state       = S_IDLE;
                end else if (i_status.empty) begin
                    o_cmd.insert  = 1'b1;
                    o_cmd.emit    = 1'b1;
                    o_cmd.verdict = asbc_pkg::V_LEARNED;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.hit) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.verdict = i_status.mac_eq ? asbc_pkg::V_MATCH
                                                    : asbc_pkg::V_SPOOF;
                    n_state       = S_IDLE;
                end else if (i_status.miss) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.full) begin
                        o_cmd.verdict = asbc_pkg::V_FULL;
                    end else begin
                        o_cmd.insert  = 1'b1;
                        o_cmd.verdict = asbc_pkg::V_LEARNED;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> design/asbc_dp.sv
// datapath of the arp spoof binding checker: binding memory, search, result
// depends on asbc_pkg
`default_nettype none

module asbc_dp #(
    parameter int TABLE_DEPTH = asbc_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire asbc_pkg::t_cmd                i_cmd,
    input  wire logic [asbc_pkg::OPCODE_W-1:0] i_arp_opcode,
    input  wire logic [asbc_pkg::IP_W-1:0]     i_sender_ip,
    input  wire logic [asbc_pkg::MAC_W-1:0]    i_sender_mac,
    output asbc_pkg::t_status                  o_status,
    output logic                               o_strobe,
    output logic [asbc_pkg::VERDICT_W-1:0]     o_verdict,
    output logic [asbc_pkg::MAC_W-1:0]         o_bound_mac,
    output logic [asbc_pkg::COUNT_W-1:0]       o_entry_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // captured word
    logic [asbc_pkg::OPCODE_W-1:0] r_op;
    logic [asbc_pkg::IP_W-1:0]     r_ip;
    logic [asbc_pkg::MAC_W-1:0]    r_mac_in;

    // table, filled in order so entries below r_fill are the valid ones
    logic [asbc_pkg::IP_W-1:0]  r_ip_mem  [TABLE_DEPTH];
    logic [asbc_pkg::MAC_W-1:0] r_mac_mem [TABLE_DEPTH];
    logic [asbc_pkg::IP_W-1:0]  r_rd_ip;
    logic [asbc_pkg::MAC_W-1:0] r_rd_mac;

    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    logic          r_halted;
    logic [AW-1:0] r_addr;
    logic          r_issue;
    logic          r_rd_vld;
    logic          r_rd_last;

    logic                       r_strobe;
    asbc_pkg::t_verdict         r_verdict;
    logic [asbc_pkg::MAC_W-1:0] r_mac_out;

    logic [AW-1:0] last_idx;
    logic [AW-1:0] fill_addr;
    logic          ip_eq;

    assign last_idx  = AW'(r_fill - CW'(1));
    assign fill_addr = r_fill[AW-1:0];
    assign ip_eq     = (r_rd_ip == r_ip);
    assign n_fill    = i_cmd.insert ? r_fill + CW'(1) : r_fill;

    always_comb begin
        o_status.halted = r_halted;
        o_status.op_ok  = (r_op == asbc_pkg::OP_REQUEST) || (r_op == asbc_pkg::OP_REPLY);
        o_status.empty  = (r_fill == '0);
        o_status.full   = (r_fill == CW'(TABLE_DEPTH));
        o_status.hit    = r_rd_vld && ip_eq;
        o_status.miss   = r_rd_vld && r_rd_last && !ip_eq;
        o_status.mac_eq = (r_rd_mac == r_mac_in);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_arp_opcode;
            r_ip     <= i_sender_ip;
            r_mac_in <= i_sender_mac;
        end
    end

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_ip_mem[fill_addr]  <= r_ip;
            r_mac_mem[fill_addr] <= r_mac_in;
        end
        r_rd_ip  <= r_ip_mem[r_addr];
        r_rd_mac <= r_mac_mem[r_addr];
    end

    // search address walk; the valid tag is registered alongside the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_issue && !i_cmd.emit;
            if (i_cmd.scan_start) begin
                r_issue <= 1'b1;
            end else if (i_cmd.emit) begin
                r_issue <= 1'b0;
            end else if (r_issue && (r_addr == last_idx)) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= (r_addr == last_idx);
        if (i_cmd.scan_start) begin
            r_addr <= '0;
        end else if (r_issue && (r_addr != last_idx)) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_halted <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_strobe <= i_cmd.emit;
            if (i_cmd.emit && (i_cmd.verdict == asbc_pkg::V_SPOOF)) begin
                r_halted <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_verdict <= i_cmd.verdict;
            if ((i_cmd.verdict == asbc_pkg::V_MATCH) ||
                (i_cmd.verdict == asbc_pkg::V_SPOOF)) begin
                r_mac_out <= r_rd_mac;
            end else begin
                r_mac_out <= '0;
            end
        end
    end

    assign o_strobe      = r_strobe;
    assign o_verdict     = r_verdict;
    assign o_bound_mac   = r_mac_out;
    // count changes only on insert, so it is stable through the result cycle
    assign o_entry_count = asbc_pkg::COUNT_W'(r_fill);

endmodule

`default_nettype wire

>>> design/arp_spoof_binding_checker.sv
// top level of the arp spoof binding checker: controller plus datapath
// depends on asbc_pkg, asbc_ctrl and asbc_dp
//
// A word (opcode, sender ip, sender mac) is taken at a rising edge where start
// is high and busy is low; busy then stays high until the verdict is decided.
// Each word gives exactly one result, shown on the o_ ports for one cycle with
// o_strobe high; the receiver cannot hold it off, so it must take it then.
// Halted and unknown-opcode words, and the first word into an empty table, are
// decided in the check state. Otherwise the table is searched one entry per clock
// through a single memory read port with registered data, from entry zero until
// the ip is found or the last filled entry is read. The result appears in the same
// cycle that busy falls, and a new word may start in that same cycle. The table is
// empty after reset with no clearing pass.
`default_nettype none

module arp_spoof_binding_checker #(
    parameter int TABLE_DEPTH = asbc_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [asbc_pkg::OPCODE_W-1:0] i_arp_opcode,
    input  wire logic [asbc_pkg::IP_W-1:0]     i_sender_ip,
    input  wire logic [asbc_pkg::MAC_W-1:0]    i_sender_mac,
    output logic                               o_strobe,
    output logic [asbc_pkg::VERDICT_W-1:0]     o_verdict,
    output logic [asbc_pkg::MAC_W-1:0]         o_bound_mac,
    output logic [asbc_pkg::COUNT_W-1:0]       o_entry_count
);

    asbc_pkg::t_cmd    cmd;
    asbc_pkg::t_status status;

    // sequencing: accept, opcode and halt check, table search, decision
    asbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // binding memory, fill count, halt flag and result registers
    asbc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_arp_opcode  (i_arp_opcode),
        .i_sender_ip   (i_sender_ip),
        .i_sender_mac  (i_sender_mac),
        .o_status      (status),
        .o_strobe      (o_strobe),
        .o_verdict     (o_verdict),
        .o_bound_mac   (o_bound_mac),
        .o_entry_count (o_entry_count)
    );

    // a result only follows a word that was in progress
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a word in progress");

    // never write a binding into a full table
    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.insert |-> !status.full)
        else $error("insert while table full");

    // a learned word grows the count by exactly one
    a_learn_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_verdict == asbc_pkg::V_LEARNED)) |->
        (o_entry_count == asbc_pkg::COUNT_W'($past(o_entry_count) + 1'b1)))
        else $error("learned word did not bump the entry count");

    // bound mac is only reported on match or spoof
    a_mac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_verdict != asbc_pkg::V_MATCH) &&
         (o_verdict != asbc_pkg::V_SPOOF)) |-> (o_bound_mac == '0))
        else $error("bound mac not zero for this verdict");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// self-checking testbench for arp_spoof_binding_checker: start/busy word driver,
// strobe monitor and a binding table predictor scored word by word
// depends on asbc_pkg and the arp_spoof_binding_checker rtl
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH       = asbc_pkg::TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;  // ~5x the slowest legal run
    localparam int TAIL_CYCLES = 80;      // longest search plus result slot
    localparam int RANDOM_WORDS = 1000;
    localparam int HALT_WORDS  = 24;

    // one arp packet word plus how the driver should pace it
    typedef struct {
        logic [asbc_pkg::OPCODE_W-1:0] opcode;
        logic [asbc_pkg::IP_W-1:0]     ip;
        logic [asbc_pkg::MAC_W-1:0]    mac;
        int unsigned                   idle_pct;   // chance per cycle that start stays low
        bit                            hold;       // wait for every verdict before sending
    } t_arp_word;

    typedef struct {
        asbc_pkg::t_verdict           verdict;
        logic [asbc_pkg::MAC_W-1:0]   mac;
        logic [asbc_pkg::COUNT_W-1:0] count;
    } t_arp_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [asbc_pkg::OPCODE_W-1:0]  i_arp_opcode = '0;
    logic [asbc_pkg::IP_W-1:0]      i_sender_ip = '0;
    logic [asbc_pkg::MAC_W-1:0]     i_sender_mac = '0;
    logic                           o_strobe;
    logic [asbc_pkg::VERDICT_W-1:0] o_verdict;
    logic [asbc_pkg::MAC_W-1:0]     o_bound_mac;
    logic [asbc_pkg::COUNT_W-1:0]   o_entry_count;

    arp_spoof_binding_checker #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_arp_opcode  (i_arp_opcode),
        .i_sender_ip   (i_sender_ip),
        .i_sender_mac  (i_sender_mac),
        .o_strobe      (o_strobe),
        .o_verdict     (o_verdict),
        .o_bound_mac   (o_bound_mac),
        .o_entry_count (o_entry_count)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // binding table predictor: own copy of the table, fill count and the
    // latched halt, advanced once per accepted word
    // ------------------------------------------------------------------
    bit                         bind_valid [DEPTH] = '{default: 1'b0};
    logic [asbc_pkg::IP_W-1:0]  bind_ip    [DEPTH];
    logic [asbc_pkg::MAC_W-1:0] bind_mac   [DEPTH];
    int                         bind_count = 0;
    bit                         spoof_latched = 1'b0;

    function automatic t_arp_result judge_arp_word(
            input logic [asbc_pkg::OPCODE_W-1:0] op,
            input logic [asbc_pkg::IP_W-1:0] ip,
            input logic [asbc_pkg::MAC_W-1:0] mac);
        t_arp_result res;
        int          hit;
        res.mac = '0;
        hit = -1;
        if (spoof_latched) begin
            // after a spoof nothing is compared or learned
            res.verdict = asbc_pkg::V_HALTED;
        end else if (op != asbc_pkg::OP_REQUEST && op != asbc_pkg::OP_REPLY) begin
            res.verdict = asbc_pkg::V_UNKNOWN;
        end else begin
            for (int k = 0; k < DEPTH; k++) begin
                if (hit < 0 && bind_valid[k] && bind_ip[k] == ip) hit = k;
            end
            if (hit < 0) begin
                if (bind_count >= DEPTH) begin
                    res.verdict = asbc_pkg::V_FULL;
                end else begin
                    // new ip goes into the next free slot
                    bind_valid[bind_count] = 1'b1;
                    bind_ip[bind_count] = ip;
                    bind_mac[bind_count] = mac;
                    bind_count++;
                    res.verdict = asbc_pkg::V_LEARNED;
                end
            end else if (bind_mac[hit] == mac) begin
                res.verdict = asbc_pkg::V_MATCH;
                res.mac = bind_mac[hit];
            end else begin
                // binding changed: report the stored mac, then stop for good
                res.verdict = asbc_pkg::V_SPOOF;
                res.mac = bind_mac[hit];
                spoof_latched = 1'b1;
            end
        end
        res.count = asbc_pkg::COUNT_W'(bind_count);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation: the whole word list is built up front, since
    // the verdict sequence does not depend on timing
    // ------------------------------------------------------------------
    t_arp_word                  pending_words[$];
    logic [asbc_pkg::IP_W-1:0]  gen_ips[$];     // ips the table should hold, in slot order
    logic [asbc_pkg::MAC_W-1:0] gen_macs[$];
    int unsigned                gen_idle = 15;
    bit                         gen_hold = 1'b0;
    int                         total_words = 0;

    function automatic logic [asbc_pkg::MAC_W-1:0] rand_mac();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom();
        hi = $urandom();
        return {hi[15:0], lo};
    endfunction

    function automatic bit ip_is_bound(input logic [asbc_pkg::IP_W-1:0] ip);
        foreach (gen_ips[k]) begin
            if (gen_ips[k] == ip) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [asbc_pkg::IP_W-1:0] fresh_ip();
        logic [asbc_pkg::IP_W-1:0] ip;
        do ip = $urandom(); while (ip_is_bound(ip));
        return ip;
    endfunction

    function automatic logic [asbc_pkg::OPCODE_W-1:0] rand_arp_op();
        return ($urandom_range(0, 1) == 0) ? asbc_pkg::OP_REQUEST : asbc_pkg::OP_REPLY;
    endfunction

    function automatic logic [asbc_pkg::OPCODE_W-1:0] rand_any_op();
        return asbc_pkg::OPCODE_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // append a word; also track what the table will learn so that later
    // matches can be aimed at bound ips
    task automatic queue_word(input logic [asbc_pkg::OPCODE_W-1:0] op,
            input logic [asbc_pkg::IP_W-1:0] ip, input logic [asbc_pkg::MAC_W-1:0] mac);
        t_arp_word w;
        w.opcode = op;
        w.ip = ip;
        w.mac = mac;
        w.idle_pct = gen_idle;
        w.hold = gen_hold;
        gen_hold = 1'b0;
        if ((op == asbc_pkg::OP_REQUEST || op == asbc_pkg::OP_REPLY) && !ip_is_bound(ip)
                && gen_ips.size() < DEPTH) begin
            gen_ips.push_back(ip);
            gen_macs.push_back(mac);
        end
        pending_words.push_back(w);
    endtask

    task automatic build_stimulus();
        int unsigned                   r;
        int                            idx;
        logic [asbc_pkg::OPCODE_W-1:0] op;
        logic [asbc_pkg::MAC_W-1:0]    flip;

        // directed: first word into an empty table, field extremes,
        // matches, unknown opcodes on bound ips with a foreign mac and on one unbound ip
        queue_word(asbc_pkg::OP_REQUEST, 32'h0000_0000, 48'h0000_0000_0000);
        queue_word(asbc_pkg::OP_REPLY,   32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_word(asbc_pkg::OP_REPLY,   32'h0000_0000, 48'h0000_0000_0000);
        queue_word(asbc_pkg::OP_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_word(16'h0000,   32'h0000_0000, 48'h0000_0000_0001);
        queue_word(16'h0003,   32'hFFFF_FFFF, 48'h0000_0000_0000);
        queue_word(16'hFFFF,   32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        queue_word(16'h8000,   32'h1234_5678, 48'h9ABC_DEF0_1234);
        queue_word(16'h0100,   32'h0000_0000, 48'h1111_1111_1111);  // byte-swapped request
        queue_word(16'h0200,   32'hFFFF_FFFF, 48'h2222_2222_2222);  // byte-swapped reply
        queue_word(asbc_pkg::OP_REQUEST, 32'h8000_0000, 48'h8000_0000_0000);
        queue_word(asbc_pkg::OP_REPLY,   32'h8000_0000, 48'h8000_0000_0000);
        // same mac behind two ips is legal
        queue_word(asbc_pkg::OP_REQUEST, 32'hC0A8_0001, 48'h0000_0000_0001);
        queue_word(asbc_pkg::OP_REPLY,   32'hC0A8_0002, 48'h0000_0000_0001);
        queue_word(asbc_pkg::OP_REQUEST, 32'hC0A8_0001, 48'h0000_0000_0001);
        queue_word(asbc_pkg::OP_REPLY,   32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
        queue_word(asbc_pkg::OP_REPLY,   32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);

        // random traffic: mostly well-formed requests and replies against
        // bound ips, a steady trickle of new ips that fills the table
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 340) begin
                gen_idle = 66;
                gen_hold = 1'b1;
            end
            if (n == 680) begin
                gen_idle = 0;
                gen_hold = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 14 || gen_ips.size() == 0) begin
                queue_word(rand_arp_op(), fresh_ip(), rand_mac());
            end else if (r < 64) begin
                idx = $urandom_range(0, gen_ips.size() - 1);
                queue_word(rand_arp_op(), gen_ips[idx], gen_macs[idx]);
            end else if (r < 82) begin
                do op = rand_any_op();
                while (op == asbc_pkg::OP_REQUEST || op == asbc_pkg::OP_REPLY);
                if (r < 73) begin
                    idx = $urandom_range(0, gen_ips.size() - 1);
                    queue_word(op, gen_ips[idx], rand_mac());
                end else begin
                    queue_word(op, $urandom(), rand_mac());
                end
            end else begin
                // first and last slot: shortest and longest search
                idx = (r < 91) ? gen_ips.size() - 1 : 0;
                queue_word(rand_arp_op(), gen_ips[idx], gen_macs[idx]);
            end
        end

        // a spoof on a bound ip, after which every word answers halted
        gen_hold = 1'b1;
        idx = $urandom_range(0, gen_ips.size() - 1);
        do flip = rand_mac(); while (flip == '0);
        queue_word(rand_arp_op(), gen_ips[idx], gen_macs[idx] ^ flip);
        for (int n = 0; n < HALT_WORDS; n++) begin
            r = $urandom_range(0, 3);
            idx = $urandom_range(0, gen_ips.size() - 1);
            case (r)
                0: begin
                    queue_word(rand_arp_op(), gen_ips[idx], gen_macs[idx]);
                end
                1: begin
                    queue_word(rand_arp_op(), fresh_ip(), rand_mac());
                end
                2: begin
                    queue_word(rand_arp_op(), gen_ips[idx], rand_mac());
                end
                default: begin
                    queue_word(rand_any_op(), $urandom(), rand_mac());
                end
            endcase
        end
        total_words = pending_words.size();
    endtask

    // ------------------------------------------------------------------
    // driver: one word in flight, start dropped at random per cycle so
    // that gaps land on every phase of a search
    // ------------------------------------------------------------------
    t_arp_word cur_word;
    bit        have_word = 1'b0;
    int        words_sent = 0;     // nba, read by other processes
    int        words_checked = 0;  // nba, owned by the monitor

    always @(posedge i_clk) begin
        bit accepted;
        bit go;
        accepted = start && !busy;
        go = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (accepted) begin
                have_word = 1'b0;
                words_sent <= words_sent + 1;
            end
            if (!have_word && pending_words.size() != 0) begin
                cur_word = pending_words.pop_front();
                have_word = 1'b1;
                i_arp_opcode <= cur_word.opcode;
                i_sender_ip <= cur_word.ip;
                i_sender_mac <= cur_word.mac;
            end
            if (have_word) begin
                go = ($urandom_range(0, 99) >= cur_word.idle_pct);
                // a held word waits until the block has answered everything
                if (cur_word.hold && (accepted || words_sent != words_checked)) go = 1'b0;
            end
            start <= go;
        end
    end

    // ------------------------------------------------------------------
    // monitor: score the strobed result against the oldest expectation,
    // then predict for a word accepted at this edge
    // ------------------------------------------------------------------
    t_arp_result verdict_q[$];
    int          mismatches = 0;
    int          verdict_seen [6] = '{default: 0};

    always @(posedge i_clk) begin
        t_arp_result exp_res;
        if (i_rst_n) begin
            if (o_strobe) begin
                words_checked <= words_checked + 1;
                if (verdict_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result: verdict %0d mac %h count %0d",
                                 o_verdict, o_bound_mac, o_entry_count);
                    end
                    mismatches++;
                end else begin
                    exp_res = verdict_q.pop_front();
                    if (o_verdict !== exp_res.verdict || o_bound_mac !== exp_res.mac
                            || o_entry_count !== exp_res.count) begin
                        if (mismatches < 10) begin
                            $display("mismatch at word %0d: expected %0d/%h/%0d got %0d/%h/%0d",
                                     words_checked, exp_res.verdict, exp_res.mac,
                                     exp_res.count, o_verdict, o_bound_mac, o_entry_count);
                        end
                        mismatches++;
                    end
                end
            end
            if (start && !busy) begin
                exp_res = judge_arp_word(i_arp_opcode, i_sender_ip, i_sender_mac);
                verdict_seen[exp_res.verdict]++;
                verdict_q.push_back(exp_res);
            end
        end
    end

    // ------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------
    int cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("arp_spoof_binding_checker regression: fail");
        $finish;
    end

    initial begin
        build_stimulus();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // every word accepted and every verdict back
        while (!(words_sent == total_words && words_checked >= total_words)) begin
            @(posedge i_clk);
        end
        // quiet tail: catch stray strobes
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d words: learned %0d, match %0d, spoof %0d, unknown %0d, full %0d",
                 total_words, verdict_seen[asbc_pkg::V_LEARNED],
                 verdict_seen[asbc_pkg::V_MATCH], verdict_seen[asbc_pkg::V_SPOOF],
                 verdict_seen[asbc_pkg::V_UNKNOWN], verdict_seen[asbc_pkg::V_FULL]);
        $display("halted %0d, bindings held %0d, mismatches %0d, verdicts outstanding %0d",
                 verdict_seen[asbc_pkg::V_HALTED], bind_count, mismatches,
                 verdict_q.size());
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("arp_spoof_binding_checker regression: pass");
        end else begin
            $display("arp_spoof_binding_checker regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
design/asbc_pkg.sv
design/asbc_ctrl.sv
design/asbc_dp.sv
design/arp_spoof_binding_checker.sv
sim/tb_top.sv
